/* src/command_line_tokenizer_core_macros.svh */
// Assertion macros for the command line tokenizer core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef COMMAND_LINE_TOKENIZER_CORE_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CLT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/clt_pkg.sv */
// Shared types and constants of the command line tokenizer.
// No dependencies; imported by every module of the block.
package clt_pkg;

  localparam int unsigned LINE_LENGTH = 128;
  localparam int unsigned ARG_LIMIT   = 16;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ARG_CNT_W = $clog2(ARG_LIMIT + 1);

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] ESC_RESET  = 8'h5C;

  localparam int unsigned RESQ_DEPTH = 4;
  localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int unsigned RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_BEGIN  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_TOO_MANY   = 3'd2,
    ST_TRAIL_ESC  = 3'd3,
    ST_OPEN_QUOTE = 3'd4
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] value;
    logic [IDX_W-1:0]  arg_index;
    status_e           status;
    logic              last;
  } res_t;

  // Up to two results produced by one item, r0 first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(kind_e k, logic [POS_W-1:0] p, logic [CHAR_W-1:0] v,
                                  logic [IDX_W-1:0] i, status_e s);
    res_t r;
    r.kind      = k;
    r.position  = p;
    r.value     = v;
    r.arg_index = i;
    r.status    = s;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

/* src/command_line_tokenizer_core.sv */
// Command line tokenizer core: one character per item in, argument events out.
// Results of an item are registered in the result queue when the item is taken.
// Throughput: one item per cycle while each yields at most one result and the
// master accepts; items with two results are buffered in a four-entry result queue.
// Reset (rst_ni low, asynchronous): line state cleared, escape character 0x5C.
// Depends on clt_pkg, clt_engine, clt_resq and the assertion macro header.
`include "command_line_tokenizer_core_macros.svh"

module command_line_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] position, [15:8] value,
                                      // [19:16] arg_index, [22:20] status, [23] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last result caused by the input item
  // escape character register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import clt_pkg::*;

  logic  in_fire;
  push_t push;
  res_t  head;

  // Take a new item whenever the queue can absorb the worst case of two results.
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  // Accept a register write in any cycle; the sender keeps writes to idle stretches.
  assign cfg_ready_o = 1'b1;

  clt_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .ch_i       (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push)
  );

  clt_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (head)
  );

  // Pack the head result onto the stream.
  assign m_axis_tdata = {1'b0, head.status, head.arg_index, head.value, head.position};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // An item never produces more than two results.
  `CLT_ASSERT_IMPL(a_push_max_two, 1'b1, push.cnt != 2'd3, "more than two results per item")
  // Results come only from an accepted item.
  `CLT_ASSERT_IMPL(a_push_needs_item, push.cnt != 2'd0, in_fire, "result without an item")
  // With two results, only the second carries the last mark.
  `CLT_ASSERT_IMPL(a_pair_last, push.cnt == 2'd2, push.r1.last && !push.r0.last,
                   "last mark misplaced in a result pair")
  // A line finish is always the final result of its item.
  `CLT_ASSERT_IMPL(a_finish_last, m_axis_tvalid && (m_axis_tuser == KIND_FINISH),
                   m_axis_tlast, "finish result without last")

endmodule

/* src/clt_engine.sv */
// Tokenizer step logic: line state registers, escape register and the
// per-character decision. Depends on clt_pkg.
module clt_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_fire_i,
  input  logic [clt_pkg::CHAR_W-1:0] ch_i,
  input  logic                  cfg_we_i,
  input  logic [clt_pkg::CHAR_W-1:0] cfg_data_i,
  output clt_pkg::push_t        push_o
);
  import clt_pkg::*;

  logic [CHAR_W-1:0]    esc_char_q;
  logic [CHAR_W-1:0]    chars_q, chars_d;
  logic [POS_W-1:0]     wc_q, wc_d;
  logic [ARG_CNT_W-1:0] argcnt_q, argcnt_d;
  logic                 esc_q, esc_d;
  logic                 word_q, word_d;
  logic                 quote_q, quote_d;
  logic                 ovf_q, ovf_d;

  logic              is_term;
  logic              need_word, do_store, set_esc, clr_esc, tgl_quote, end_word;
  logic [CHAR_W-1:0] store_val;
  logic              va, vb;
  res_t              res_a, res_b;
  status_e           fin_st;

  always_comb begin
    chars_d   = chars_q;
    wc_d      = wc_q;
    argcnt_d  = argcnt_q;
    esc_d     = esc_q;
    word_d    = word_q;
    quote_d   = quote_q;
    ovf_d     = ovf_q;
    need_word = 1'b0;
    do_store  = 1'b0;
    set_esc   = 1'b0;
    clr_esc   = 1'b0;
    tgl_quote = 1'b0;
    end_word  = 1'b0;
    store_val = '0;
    va        = 1'b0;
    vb        = 1'b0;
    res_a     = mk_res(KIND_STORE, '0, '0, '0, ST_OK);
    res_b     = mk_res(KIND_STORE, '0, '0, '0, ST_OK);
    fin_st    = ST_OK;

    is_term = (ch_i == CH_NUL) || (ch_i == CH_LF) || (ch_i == CH_CR) ||
              (chars_q >= CHAR_W'(LINE_LENGTH));

    if (in_fire_i) begin
      if (is_term) begin
        if (!ovf_q) begin
          if (esc_q) begin
            fin_st = ST_TRAIL_ESC;
          end else begin
            if (word_q) begin
              va    = 1'b1;
              res_a = mk_res(KIND_STORE, wc_q, '0, '0, ST_OK);
            end
            if (quote_q) begin
              fin_st = ST_OPEN_QUOTE;
            end else if (argcnt_q == '0) begin
              fin_st = ST_EMPTY;
            end else begin
              fin_st = ST_OK;
            end
          end
          vb    = 1'b1;
          res_b = mk_res(KIND_FINISH, '0, '0, '0, fin_st);
        end
        // start a fresh line
        chars_d  = '0;
        wc_d     = '0;
        argcnt_d = '0;
        esc_d    = 1'b0;
        word_d   = 1'b0;
        quote_d  = 1'b0;
        ovf_d    = 1'b0;
      end else begin
        chars_d = chars_q + CHAR_W'(1);
        if (!ovf_q) begin
          priority if (esc_q) begin
            need_word = 1'b1;
            do_store  = 1'b1;
            store_val = ch_i;
            clr_esc   = 1'b1;
          end else if (ch_i == esc_char_q) begin
            need_word = 1'b1;
            set_esc   = 1'b1;
          end else if (ch_i == CH_SPACE) begin
            if (quote_q) begin
              need_word = 1'b1;
              do_store  = 1'b1;
              store_val = ch_i;
            end else if (word_q) begin
              do_store  = 1'b1;
              end_word  = 1'b1;
            end
          end else if (ch_i == CH_QUOTE) begin
            need_word = 1'b1;
            tgl_quote = 1'b1;
          end else begin
            need_word = 1'b1;
            do_store  = 1'b1;
            store_val = ch_i;
          end

          if (need_word && !word_q && (argcnt_q >= ARG_CNT_W'(ARG_LIMIT))) begin
            // too many arguments: finish now, drop the rest of the line
            va    = 1'b1;
            res_a = mk_res(KIND_FINISH, '0, '0, '0, ST_TOO_MANY);
            ovf_d = 1'b1;
          end else begin
            if (need_word && !word_q) begin
              va       = 1'b1;
              res_a    = mk_res(KIND_BEGIN, wc_q, '0, IDX_W'(argcnt_q), ST_OK);
              argcnt_d = argcnt_q + ARG_CNT_W'(1);
              word_d   = 1'b1;
            end
            if (do_store) begin
              vb    = 1'b1;
              res_b = mk_res(KIND_STORE, wc_q, store_val, '0, ST_OK);
              wc_d  = wc_q + POS_W'(1);
            end
            if (set_esc)   esc_d   = 1'b1;
            if (clr_esc)   esc_d   = 1'b0;
            if (tgl_quote) quote_d = !quote_q;
            if (end_word)  word_d  = 1'b0;
          end
        end
      end
    end
  end

  // Compact the two candidate results and mark the final one.
  always_comb begin
    push_o.cnt = 2'd0;
    push_o.r0  = res_a;
    push_o.r1  = res_b;
    if (va && vb) begin
      push_o.cnt     = 2'd2;
      push_o.r1.last = 1'b1;
    end else if (va) begin
      push_o.cnt     = 2'd1;
      push_o.r0.last = 1'b1;
    end else if (vb) begin
      push_o.cnt     = 2'd1;
      push_o.r0      = res_b;
      push_o.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_char_q <= ESC_RESET;
      chars_q    <= '0;
      wc_q       <= '0;
      argcnt_q   <= '0;
      esc_q      <= 1'b0;
      word_q     <= 1'b0;
      quote_q    <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        esc_char_q <= cfg_data_i;
      end
      chars_q  <= chars_d;
      wc_q     <= wc_d;
      argcnt_q <= argcnt_d;
      esc_q    <= esc_d;
      word_q   <= word_d;
      quote_q  <= quote_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

/* src/clt_resq.sv */
// Result queue: takes up to two results a cycle, hands out one.
// Depends on clt_pkg.
module clt_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clt_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output clt_pkg::res_t  res_o
);
  import clt_pkg::*;

  res_t               mem_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [RESQ_CW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= RESQ_CW'(RESQ_DEPTH - 2));
  assign res_o   = mem_q[rp_q];
  assign pop     = valid_o && ready_i;

  always_comb begin
    wp_d  = wp_q + RESQ_AW'(push_i.cnt);
    rp_d  = rp_q + RESQ_AW'(pop);
    cnt_d = cnt_q + RESQ_CW'(push_i.cnt) - RESQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + RESQ_AW'(1)] <= push_i.r1;
    end
  end

endmodule
